FILE: rtl/core/bfw_pkg.sv
package bfw_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int PIXEL_BITS = 16;

	// fixed field widths
	localparam int POS_BITS     = 9;
	localparam int FLOW_BITS    = 16;
	localparam int CFG_BITS     = 10;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_RESET_SIZE = 512;

	localparam int FRAC_BITS = 6;
	localparam int FRAC_ONE  = 1 << FRAC_BITS;
	localparam int RND_SHIFT = 2 * FRAC_BITS;

	localparam int X_BITS    = $clog2(MAX_WIDTH);
	localparam int Y_BITS    = $clog2(MAX_HEIGHT);
	localparam int ADDR_BITS = X_BITS + Y_BITS;
	localparam int STORE_DEPTH = 2 ** ADDR_BITS;

	// sample coordinate in Q.6 and its integer part
	localparam int SX_BITS = ((POS_BITS + FRAC_BITS > FLOW_BITS - 1) ?
		POS_BITS + FRAC_BITS : FLOW_BITS - 1) + 2;
	localparam int XI_BITS = SX_BITS - FRAC_BITS;
	localparam int XB_MAX  = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
	localparam int CL_BITS = (XI_BITS > XB_MAX + 1) ? XI_BITS : XB_MAX + 1;

	// blend widths
	localparam int ROW_BITS = PIXEL_BITS + FRAC_BITS + 1;
	localparam int SUM_BITS = ROW_BITS + FRAC_BITS + 1;
	localparam int RES_BITS = SUM_BITS - RND_SHIFT;

	localparam int CMDQ_DEPTH = 4;
	localparam int CQ_BITS    = $clog2(CMDQ_DEPTH);
	localparam int OUTQ_DEPTH = 4;
	localparam int OQ_BITS    = $clog2(OUTQ_DEPTH);

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_WARP = 1'b1
	} bfw_op_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} bfw_reg_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_RD1,
		BS_RD2,
		BS_RD3
	} bfw_bstate_t;

	typedef struct packed {
		bfw_op_t               op;
		logic [ADDR_BITS-1:0]  waddr;
		logic [PIXEL_BITS-1:0] wdata;
		logic [X_BITS-1:0]     cx0;
		logic [X_BITS-1:0]     cx1;
		logic [Y_BITS-1:0]     cy0;
		logic [Y_BITS-1:0]     cy1;
		logic [FRAC_BITS-1:0]  fa;
		logic [FRAC_BITS-1:0]  fb;
	} bfw_cmd_t;

	typedef struct packed {
		logic     push;
		bfw_cmd_t cmd;
	} bfw_cmdq_wr_t;

	typedef struct packed {
		logic     full;
		logic     empty;
		bfw_cmd_t head;
	} bfw_cmdq_st_t;

endpackage

FILE: rtl/core/bilinear_flow_warp.sv
// Bilinear backward warp of one image channel with the sampled neighbors clamped to the
// active frame. Load requests (mode 0) write a Q3.12 pixel into the on-chip frame store;
// warp requests (mode 1) sample at (pos_x+flow_dx, pos_y+flow_dy), flow in Q9.6, and
// return one rounded, saturated Q3.12 value. Requests run strictly in order through a
// 4-entry command queue: a load takes one write of the single-port frame memory and a
// warp one read per neighbor, so each request waits until the warp before it has issued
// all its reads. A warp starts only while fewer than 4 results are in flight, and up to
// 4 results buffer on the output. The frame store has no reset and must be loaded
// before any entry a warp touches; the frame size registers may only change while the
// block is idle.
module bilinear_flow_warp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bfw_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [bfw_pkg::CFG_BITS-1:0]          cfg_data,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  mode,
	input  logic [bfw_pkg::POS_BITS-1:0]          pos_x,
	input  logic [bfw_pkg::POS_BITS-1:0]          pos_y,
	input  logic signed [bfw_pkg::PIXEL_BITS-1:0] pixel_value,
	input  logic signed [bfw_pkg::FLOW_BITS-1:0]  flow_dx,
	input  logic signed [bfw_pkg::FLOW_BITS-1:0]  flow_dy,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [bfw_pkg::PIXEL_BITS-1:0] warped_value
);

	bfw_pkg::bfw_cmdq_wr_t q_wr;
	bfw_pkg::bfw_cmdq_st_t q_st;
	logic q_pop;
	logic ram_we;
	logic [bfw_pkg::ADDR_BITS-1:0] ram_addr;
	logic [bfw_pkg::PIXEL_BITS-1:0] ram_wdata, ram_rdata;

	bfw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pixel_value (pixel_value),
		.flow_dx     (flow_dx),
		.flow_dy     (flow_dy),
		.q_full      (q_st.full),
		.q_wr        (q_wr)
	);

	bfw_cmd_queue u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.st     (q_st)
	);

	bfw_ram #(
		.WIDTH (bfw_pkg::PIXEL_BITS),
		.DEPTH (bfw_pkg::STORE_DEPTH)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	bfw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qst          (q_st),
		.q_pop        (q_pop),
		.ram_we       (ram_we),
		.ram_addr     (ram_addr),
		.ram_wdata    (ram_wdata),
		.ram_rdata    (ram_rdata),
		.pop          (pop),
		.empty        (empty),
		.warped_value (warped_value)
	);

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> !q_st.full)
		else $error("command queue written while full");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_st.empty)
		else $error("command queue popped while empty");

	a_write_is_load: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (q_pop && q_st.head.op == bfw_pkg::CMD_LOAD))
		else $error("frame write not tied to a retiring load");

endmodule

FILE: rtl/core/bfw_ram.sv
module bfw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/bfw_front.sv
module bfw_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bfw_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [bfw_pkg::CFG_BITS-1:0]        cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic                                mode,
	input  logic [bfw_pkg::POS_BITS-1:0]        pos_x,
	input  logic [bfw_pkg::POS_BITS-1:0]        pos_y,
	input  logic signed [bfw_pkg::PIXEL_BITS-1:0] pixel_value,
	input  logic signed [bfw_pkg::FLOW_BITS-1:0]  flow_dx,
	input  logic signed [bfw_pkg::FLOW_BITS-1:0]  flow_dy,
	input  logic                                q_full,
	output bfw_pkg::bfw_cmdq_wr_t               q_wr
);

	localparam int CL = bfw_pkg::CL_BITS;

	logic [bfw_pkg::CFG_BITS-1:0] width_q, height_q;
	logic signed [CL-1:0] w_lim, h_lim;
	logic signed [bfw_pkg::SX_BITS-1:0] sx, sy;
	logic signed [CL-1:0] x0, x1, y0, y1;
	logic [CL-1:0] cx0, cx1, cy0, cy1;
	logic in_store, accept;

	function automatic logic signed [CL-1:0] size_lim(input logic [bfw_pkg::CFG_BITS-1:0] r,
		input int maxv);
		logic signed [CL-1:0] v;
		if (r == '0) begin
			v = '0;
		end else if (32'(r) > maxv) begin
			v = CL'(maxv - 1);
		end else begin
			v = CL'(r) - CL'(1);
		end
		return v;
	endfunction

	function automatic logic [CL-1:0] clamp(input logic signed [CL-1:0] c,
		input logic signed [CL-1:0] lim);
		logic [CL-1:0] v;
		if (c < 0) begin
			v = '0;
		end else if (c > lim) begin
			v = lim;
		end else begin
			v = c;
		end
		return v;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bfw_pkg::CFG_BITS'(bfw_pkg::CFG_RESET_SIZE);
			height_q <= bfw_pkg::CFG_BITS'(bfw_pkg::CFG_RESET_SIZE);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bfw_pkg::REG_FRAME_WIDTH: begin
					width_q <= cfg_data;
				end
				bfw_pkg::REG_FRAME_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		w_lim = size_lim(width_q, bfw_pkg::MAX_WIDTH);
		h_lim = size_lim(height_q, bfw_pkg::MAX_HEIGHT);
		sx = $signed({{(bfw_pkg::SX_BITS - bfw_pkg::POS_BITS - bfw_pkg::FRAC_BITS){1'b0}},
			pos_x, {bfw_pkg::FRAC_BITS{1'b0}}}) + bfw_pkg::SX_BITS'(flow_dx);
		sy = $signed({{(bfw_pkg::SX_BITS - bfw_pkg::POS_BITS - bfw_pkg::FRAC_BITS){1'b0}},
			pos_y, {bfw_pkg::FRAC_BITS{1'b0}}}) + bfw_pkg::SX_BITS'(flow_dy);
		// floor: arithmetic drop of the fraction bits
		x0 = CL'($signed(sx[bfw_pkg::SX_BITS-1:bfw_pkg::FRAC_BITS]));
		y0 = CL'($signed(sy[bfw_pkg::SX_BITS-1:bfw_pkg::FRAC_BITS]));
		x1 = x0 + CL'(1);
		y1 = y0 + CL'(1);
		cx0 = clamp(x0, w_lim);
		cx1 = clamp(x1, w_lim);
		cy0 = clamp(y0, h_lim);
		cy1 = clamp(y1, h_lim);
	end

	assign in_store = (32'(pos_x) < bfw_pkg::MAX_WIDTH) && (32'(pos_y) < bfw_pkg::MAX_HEIGHT);
	assign accept   = push && !q_full;
	assign full     = q_full;

	always_comb begin
		q_wr.push      = accept && ((bfw_pkg::bfw_op_t'(mode) == bfw_pkg::CMD_WARP) || in_store);
		q_wr.cmd.op    = bfw_pkg::bfw_op_t'(mode);
		q_wr.cmd.waddr = {bfw_pkg::Y_BITS'(pos_y), bfw_pkg::X_BITS'(pos_x)};
		q_wr.cmd.wdata = pixel_value;
		q_wr.cmd.cx0   = cx0[bfw_pkg::X_BITS-1:0];
		q_wr.cmd.cx1   = cx1[bfw_pkg::X_BITS-1:0];
		q_wr.cmd.cy0   = cy0[bfw_pkg::Y_BITS-1:0];
		q_wr.cmd.cy1   = cy1[bfw_pkg::Y_BITS-1:0];
		q_wr.cmd.fa    = sx[bfw_pkg::FRAC_BITS-1:0];
		q_wr.cmd.fb    = sy[bfw_pkg::FRAC_BITS-1:0];
	end

endmodule

FILE: rtl/core/bfw_cmd_queue.sv
module bfw_cmd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bfw_pkg::bfw_cmdq_wr_t wr,
	input  logic                  pop,
	output bfw_pkg::bfw_cmdq_st_t st
);

	bfw_pkg::bfw_cmd_t mem_q [bfw_pkg::CMDQ_DEPTH];
	logic [bfw_pkg::CQ_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [bfw_pkg::CQ_BITS:0]   cnt_q;
	logic do_push, do_pop;

	assign do_push = wr.push && !st.full;
	assign do_pop  = pop && !st.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (bfw_pkg::CQ_BITS+1)'(do_push) - (bfw_pkg::CQ_BITS+1)'(do_pop);
		end
	end

	always_comb begin
		st.full  = (cnt_q == (bfw_pkg::CQ_BITS+1)'(bfw_pkg::CMDQ_DEPTH));
		st.empty = (cnt_q == '0);
		st.head  = mem_q[rd_ptr_q];
	end

endmodule

FILE: rtl/core/bfw_back.sv
module bfw_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bfw_pkg::bfw_cmdq_st_t           qst,
	output logic                            q_pop,
	output logic                            ram_we,
	output logic [bfw_pkg::ADDR_BITS-1:0]   ram_addr,
	output logic [bfw_pkg::PIXEL_BITS-1:0]  ram_wdata,
	input  logic [bfw_pkg::PIXEL_BITS-1:0]  ram_rdata,
	input  logic                            pop,
	output logic                            empty,
	output logic signed [bfw_pkg::PIXEL_BITS-1:0] warped_value
);

	localparam int RB = bfw_pkg::ROW_BITS;
	localparam int SB = bfw_pkg::SUM_BITS;
	localparam int PB = bfw_pkg::PIXEL_BITS;
	localparam int FB = bfw_pkg::FRAC_BITS;

	bfw_pkg::bfw_bstate_t state_q, state_d;
	bfw_pkg::bfw_cmd_t cur_q;
	logic [bfw_pkg::OQ_BITS:0] inflight_q;
	logic credit_ok, start, issue;
	logic [1:0] idx;
	logic [FB-1:0] fa_sel, fb_sel;

	// read return stage
	logic rd_vld_s1;
	logic [1:0] rd_idx_s1;
	logic [FB-1:0] rd_fa_s1, rd_fb_s1;
	logic [FB:0] row_wt;
	logic signed [RB-1:0] prod, row_sum, acc_q, top_q;

	// column blend stages
	logic vld_s2, vld_s3, vld_s4;
	logic signed [RB-1:0] top_s2, bot_s2;
	logic [FB-1:0] b_s2, b_s3;
	logic signed [SB-1:0] m_s3, bot_s3, sum_s4;
	logic [bfw_pkg::RES_BITS-1:0] res;
	logic ovf;
	logic [PB-1:0] sat;

	// result queue
	logic [PB-1:0] oq_mem_q [bfw_pkg::OUTQ_DEPTH];
	logic [bfw_pkg::OQ_BITS-1:0] owr_ptr_q, ord_ptr_q;
	logic [bfw_pkg::OQ_BITS:0] ocnt_q;
	logic out_take;

	assign credit_ok = inflight_q < (bfw_pkg::OQ_BITS+1)'(bfw_pkg::OUTQ_DEPTH);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bfw_pkg::BS_IDLE: begin
				if (!qst.empty && qst.head.op == bfw_pkg::CMD_WARP && credit_ok) begin
					state_d = bfw_pkg::BS_RD1;
				end
			end
			bfw_pkg::BS_RD1: begin
				state_d = bfw_pkg::BS_RD2;
			end
			bfw_pkg::BS_RD2: begin
				state_d = bfw_pkg::BS_RD3;
			end
			bfw_pkg::BS_RD3: begin
				state_d = bfw_pkg::BS_IDLE;
			end
			default: begin
				state_d = bfw_pkg::BS_IDLE;
			end
		endcase
	end

	// neighbor order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = qst.head.wdata;
		q_pop     = 1'b0;
		start     = 1'b0;
		issue     = 1'b0;
		idx       = 2'd0;
		fa_sel    = cur_q.fa;
		fb_sel    = cur_q.fb;
		case (state_q)
			bfw_pkg::BS_IDLE: begin
				fa_sel = qst.head.fa;
				fb_sel = qst.head.fb;
				if (!qst.empty) begin
					if (qst.head.op == bfw_pkg::CMD_LOAD) begin
						ram_we   = 1'b1;
						ram_addr = qst.head.waddr;
						q_pop    = 1'b1;
					end else if (credit_ok) begin
						ram_addr = {qst.head.cy0, qst.head.cx0};
						q_pop    = 1'b1;
						start    = 1'b1;
						issue    = 1'b1;
					end
				end
			end
			bfw_pkg::BS_RD1: begin
				ram_addr = {cur_q.cy0, cur_q.cx1};
				issue    = 1'b1;
				idx      = 2'd1;
			end
			bfw_pkg::BS_RD2: begin
				ram_addr = {cur_q.cy1, cur_q.cx0};
				issue    = 1'b1;
				idx      = 2'd2;
			end
			bfw_pkg::BS_RD3: begin
				ram_addr = {cur_q.cy1, cur_q.cx1};
				issue    = 1'b1;
				idx      = 2'd3;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bfw_pkg::BS_IDLE;
			rd_vld_s1 <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			vld_s2    <= rd_vld_s1 && (rd_idx_s1 == 2'd3);
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= qst.head;
		end
		rd_idx_s1 <= idx;
		rd_fa_s1  <= fa_sel;
		rd_fb_s1  <= fb_sel;
	end

	// row blend: one weighted neighbor per returned read
	always_comb begin
		row_wt  = rd_idx_s1[0] ? {1'b0, rd_fa_s1} : (FB+1)'(bfw_pkg::FRAC_ONE) - {1'b0, rd_fa_s1};
		prod    = RB'($signed(ram_rdata)) * $signed(RB'(row_wt));
		row_sum = acc_q + prod;
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && !rd_idx_s1[0]) begin
			acc_q <= prod;
		end
		if (rd_vld_s1 && rd_idx_s1 == 2'd1) begin
			top_q <= row_sum;
		end
		if (rd_vld_s1 && rd_idx_s1 == 2'd3) begin
			top_s2 <= top_q;
			bot_s2 <= row_sum;
			b_s2   <= rd_fb_s1;
		end
		m_s3   <= SB'(top_s2) * $signed(SB'((FB+1)'(bfw_pkg::FRAC_ONE) - {1'b0, b_s2}));
		bot_s3 <= SB'(bot_s2);
		b_s3   <= b_s2;
		sum_s4 <= m_s3 + bot_s3 * $signed(SB'(b_s3)) + SB'(1 << (bfw_pkg::RND_SHIFT - 1));
	end

	// round half up by floor shift, then saturate
	always_comb begin
		res = sum_s4[SB-1:bfw_pkg::RND_SHIFT];
		ovf = !((&res[bfw_pkg::RES_BITS-1:PB-1]) || !(|res[bfw_pkg::RES_BITS-1:PB-1]));
		if (ovf) begin
			sat = res[bfw_pkg::RES_BITS-1] ? {1'b1, {(PB-1){1'b0}}} : {1'b0, {(PB-1){1'b1}}};
		end else begin
			sat = res[PB-1:0];
		end
	end

	assign empty    = (ocnt_q == '0);
	assign out_take = pop && !empty;
	assign warped_value = oq_mem_q[ord_ptr_q];

	always_ff @(posedge clk) begin
		if (vld_s4) begin
			oq_mem_q[owr_ptr_q] <= sat;
		end
	end

	// a warp starts only with a free result slot, so the queue cannot overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q  <= '0;
			ord_ptr_q  <= '0;
			ocnt_q     <= '0;
			inflight_q <= '0;
		end else begin
			if (vld_s4) begin
				owr_ptr_q <= owr_ptr_q + 1'b1;
			end
			if (out_take) begin
				ord_ptr_q <= ord_ptr_q + 1'b1;
			end
			ocnt_q <= ocnt_q + (bfw_pkg::OQ_BITS+1)'(vld_s4)
				- (bfw_pkg::OQ_BITS+1)'(out_take);
			inflight_q <= inflight_q + (bfw_pkg::OQ_BITS+1)'(start)
				- (bfw_pkg::OQ_BITS+1)'(out_take);
		end
	end

endmodule
